### rtl/core/svpwm_pkg.sv
package svpwm_pkg;

    // Field widths
    localparam int IN_W    = 16;
    localparam int DUTY_W  = 16;
    localparam int SEXT_W  = 3;

    // 1/sqrt3 in unsigned Q0.16, held as a positive signed 17-bit constant
    localparam int K_W = 17;
    localparam logic signed [K_W-1:0] ONE_BY_SQRT3_Q16 = 17'sd37837;

    // beta/sqrt3 product width (Q.30)
    localparam int BSCL_W = IN_W + K_W;

    // Working width for the doubled duties (Q.31) with headroom
    localparam int ACC_W = 36;

    // Sextant codes
    localparam logic [SEXT_W-1:0] SEXT_1 = 3'd1;
    localparam logic [SEXT_W-1:0] SEXT_2 = 3'd2;
    localparam logic [SEXT_W-1:0] SEXT_3 = 3'd3;
    localparam logic [SEXT_W-1:0] SEXT_4 = 3'd4;
    localparam logic [SEXT_W-1:0] SEXT_5 = 3'd5;
    localparam logic [SEXT_W-1:0] SEXT_6 = 3'd6;

    // Full-scale duty in Q1.15
    localparam logic [DUTY_W-1:0] DUTY_FULL = 16'd32768;

    // One result beat
    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
        logic [SEXT_W-1:0] sextant;
        logic              in_range;
    } t_svpwm_res;

endpackage

### rtl/core/svpwm_solve.sv
module svpwm_solve
    import svpwm_pkg::*;
(
    input  logic signed [IN_W-1:0]   i_alpha,
    input  logic signed [BSCL_W-1:0] i_bscl,
    output t_svpwm_res               o_res
);

    localparam logic signed [ACC_W-1:0] ONE_Q30 = ACC_W'(64'sd1 <<< 30);
    localparam logic signed [ACC_W-1:0] ONE_Q31 = ACC_W'(64'sd1 <<< 31);

    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] a2;
    logic signed [ACC_W-1:0] b2;
    logic signed [ACC_W-1:0] b3;
    logic signed [ACC_W-1:0] neg_b;
    logic                    b_gt_a;
    logic                    nb_gt_a;
    logic [SEXT_W-1:0]       sext;
    logic signed [ACC_W-1:0] da;
    logic signed [ACC_W-1:0] db;
    logic signed [ACC_W-1:0] dc;
    logic                    ok_a;
    logic                    ok_b;
    logic                    ok_c;
    logic [DUTY_W-1:0]       q_a;
    logic [DUTY_W-1:0]       q_b;
    logic [DUTY_W-1:0]       q_c;

    // Q.31 duty -> saturated Q1.15, round to nearest with ties upward
    function automatic logic [DUTY_W:0] to_q15(input logic signed [ACC_W-1:0] d);
        logic [31:0] rnd;
        logic [DUTY_W:0] res;
        rnd = d[31:0] + 32'd32768;
        if (d < 0) begin
            res = {1'b0, {DUTY_W{1'b0}}};
        end else if (d > ONE_Q31) begin
            res = {1'b0, DUTY_FULL};
        end else begin
            res = {1'b1, rnd[31:16]};
        end
        return res;
    endfunction

    // alpha to Q.30, beta/sqrt3 already Q.30
    assign a     = {{(ACC_W-IN_W-16){i_alpha[IN_W-1]}}, i_alpha, 16'd0};
    assign b     = {{(ACC_W-BSCL_W){i_bscl[BSCL_W-1]}}, i_bscl};
    assign a2    = a <<< 1;
    assign b2    = b <<< 1;
    assign b3    = b2 + b;
    assign neg_b = -b;

    // strict compares on exact products
    assign b_gt_a  = b > a;
    assign nb_gt_a = neg_b > a;

    // sextant: zero alpha and zero beta count as nonnegative
    always_comb begin
        if (!i_bscl[BSCL_W-1]) begin
            if (!i_alpha[IN_W-1]) sext = b_gt_a ? SEXT_2 : SEXT_1;
            else                  sext = nb_gt_a ? SEXT_3 : SEXT_2;
        end else begin
            if (!i_alpha[IN_W-1]) sext = nb_gt_a ? SEXT_5 : SEXT_6;
            else                  sext = b_gt_a ? SEXT_4 : SEXT_5;
        end
    end

    // doubled duties, closed form per sextant
    always_comb begin
        case (sext)
            SEXT_1: begin
                da = ONE_Q30 - a - b;
                db = ONE_Q30 + a - b3;
                dc = ONE_Q30 + a + b;
            end
            SEXT_2: begin
                da = ONE_Q30 - a2;
                db = ONE_Q30 - b2;
                dc = ONE_Q30 + b2;
            end
            SEXT_3: begin
                da = ONE_Q30 - a + b;
                db = ONE_Q30 + a - b;
                dc = ONE_Q30 + a + b3;
            end
            SEXT_4: begin
                da = ONE_Q30 - a - b;
                db = ONE_Q30 + a - b3;
                dc = ONE_Q30 + a + b;
            end
            SEXT_5: begin
                da = ONE_Q30 - a2;
                db = ONE_Q30 - b2;
                dc = ONE_Q30 + b2;
            end
            default: begin
                da = ONE_Q30 - a + b;
                db = ONE_Q30 + a - b;
                dc = ONE_Q30 + a + b3;
            end
        endcase
    end

    // saturate and round
    assign {ok_a, q_a} = to_q15(da);
    assign {ok_b, q_b} = to_q15(db);
    assign {ok_c, q_c} = to_q15(dc);

    assign o_res.duty_a   = q_a;
    assign o_res.duty_b   = q_b;
    assign o_res.duty_c   = q_c;
    assign o_res.sextant  = sext;
    assign o_res.in_range = ok_a & ok_b & ok_c;

endmodule

### rtl/core/space_vector_pwm_sextant_core.sv
// Space vector PWM, sextant method.
// The stage 1 and stage 2 registers lie between the accepting edge and the o_valid beat.
// Throughput: one vector per clock; busy stays low, start is taken every cycle.
// Stage 1 holds alpha and the beta/sqrt3 product, stage 2 the duties, sextant and range flag.
// Synchronous active-low reset clears both valid bits; the receiver cannot stall.
module space_vector_pwm_sextant_core
    import svpwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic signed [IN_W-1:0]  i_alpha_norm,
    input  logic signed [IN_W-1:0]  i_beta_norm,
    output logic                    busy,
    output logic                    o_valid,
    output logic [DUTY_W-1:0]       o_duty_a,
    output logic [DUTY_W-1:0]       o_duty_b,
    output logic [DUTY_W-1:0]       o_duty_c,
    output logic [SEXT_W-1:0]       o_sextant,
    output logic                    o_in_range
);

    logic                     r_s1_vld;
    logic signed [IN_W-1:0]   r_s1_alpha;
    logic signed [BSCL_W-1:0] r_s1_bscl;
    logic signed [BSCL_W-1:0] n_s1_bscl;
    logic                     r_out_vld;
    t_svpwm_res               r_res;
    t_svpwm_res               n_res;

    // never backs off the sender
    assign busy = 1'b0;

    // beta / sqrt3 in Q.30
    assign n_s1_bscl = BSCL_W'(i_beta_norm) * BSCL_W'(ONE_BY_SQRT3_Q16);

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_alpha <= i_alpha_norm;
        r_s1_bscl  <= n_s1_bscl;
    end

    // sextant, duties, saturation
    svpwm_solve u_solve (
        .i_alpha (r_s1_alpha),
        .i_bscl  (r_s1_bscl),
        .o_res   (n_res)
    );

    // stage 2: result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid    = r_out_vld;
    assign o_duty_a   = r_res.duty_a;
    assign o_duty_b   = r_res.duty_b;
    assign o_duty_c   = r_res.duty_c;
    assign o_sextant  = r_res.sextant;
    assign o_in_range = r_res.in_range;

endmodule

### rtl/core/svpwm_chk.sv
module svpwm_chk
    import svpwm_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_valid,
    input logic [DUTY_W-1:0]      o_duty_a,
    input logic [DUTY_W-1:0]      o_duty_b,
    input logic [DUTY_W-1:0]      o_duty_c,
    input logic [SEXT_W-1:0]      o_sextant,
    input logic                   o_in_range
);

    // every accepted vector gives exactly one result beat, and every beat matches an accepted vector
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_rst_n, 2)) |-> (o_valid == $past(start && !busy, 2)))
        else $error("result beat does not match accepted vector");

    // sextant code is one of the six
    a_sextant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sextant == SEXT_1 || o_sextant == SEXT_2 || o_sextant == SEXT_3 ||
                     o_sextant == SEXT_4 || o_sextant == SEXT_5 || o_sextant == SEXT_6))
        else $error("bad sextant code");

    // duties never exceed full scale
    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duty_a <= DUTY_FULL && o_duty_b <= DUTY_FULL && o_duty_c <= DUTY_FULL))
        else $error("duty above full scale");

    // out of range means at least one duty sits on a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |->
            (o_duty_a == '0 || o_duty_a == DUTY_FULL ||
             o_duty_b == '0 || o_duty_b == DUTY_FULL ||
             o_duty_c == '0 || o_duty_c == DUTY_FULL))
        else $error("range flag cleared with no saturated duty");

endmodule

bind space_vector_pwm_sextant_core svpwm_chk u_svpwm_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_duty_a   (o_duty_a),
    .o_duty_b   (o_duty_b),
    .o_duty_c   (o_duty_c),
    .o_sextant  (o_sextant),
    .o_in_range (o_in_range)
);

### sim/tb_space_vector_pwm_sextant_core.sv
module tb_space_vector_pwm_sextant_core;
    import svpwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_VECS   = 1000;
    localparam int STALL_LIMIT   = 500;
    localparam int SETTLE_CYCLES = 10;

    // One directed vector; known rows carry a hand-derived result
    typedef struct {
        logic signed [IN_W-1:0] alpha;
        logic signed [IN_W-1:0] beta;
        bit                     known;
        t_svpwm_res             res;
    } t_vec_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic signed [IN_W-1:0] i_alpha_norm;
    logic signed [IN_W-1:0] i_beta_norm;
    logic                   busy;
    logic                   o_valid;
    logic [DUTY_W-1:0]      o_duty_a;
    logic [DUTY_W-1:0]      o_duty_b;
    logic [DUTY_W-1:0]      o_duty_c;
    logic [SEXT_W-1:0]      o_sextant;
    logic                   o_in_range;

    // Side-band to the checker: use the typed result instead of the predictor
    bit         vec_known;
    t_svpwm_res vec_known_res;

    t_svpwm_res duty_q[$];
    t_vec_row   vec_rows[$];
    int         n_errors;
    int         idle_cycles;
    bit         gaps_on;

    space_vector_pwm_sextant_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_alpha_norm (i_alpha_norm),
        .i_beta_norm  (i_beta_norm),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_duty_a     (o_duty_a),
        .o_duty_b     (o_duty_b),
        .o_duty_c     (o_duty_c),
        .o_sextant    (o_sextant),
        .o_in_range   (o_in_range)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Doubled duty (Q.31) to saturated Q1.15; clears ok when out of [0,1]
    function automatic logic [DUTY_W-1:0] sat_q15(longint d, inout logic ok);
        if (d < 0) begin
            ok = 1'b0;
            return '0;
        end
        if (d > (longint'(1) << 31)) begin
            ok = 1'b0;
            return DUTY_FULL;
        end
        return DUTY_W'((d + 32768) >> 16);
    endfunction

    // Sextant and centered duties for one alpha/beta vector
    function automatic t_svpwm_res svm_duties(logic signed [IN_W-1:0] alpha,
                                              logic signed [IN_W-1:0] beta);
        longint     a_q30;
        longint     b_q30;
        longint     one_q30;
        longint     tx;
        longint     ty;
        longint     da;
        longint     db;
        longint     dc;
        logic       ok;
        t_svpwm_res r;
        a_q30   = longint'(alpha) * 65536;
        b_q30   = longint'(beta) * longint'(ONE_BY_SQRT3_Q16);
        one_q30 = longint'(1) << 30;
        ok      = 1'b1;

        // Zero alpha or beta counts as nonnegative; border compare is strict
        if (beta >= 0) begin
            if (alpha >= 0) r.sextant = (b_q30 > a_q30) ? SEXT_2 : SEXT_1;
            else            r.sextant = (-b_q30 > a_q30) ? SEXT_3 : SEXT_2;
        end else begin
            if (alpha >= 0) r.sextant = (-b_q30 > a_q30) ? SEXT_5 : SEXT_6;
            else            r.sextant = (b_q30 > a_q30) ? SEXT_4 : SEXT_5;
        end

        // Active-vector on-times and duties, all doubled
        case (r.sextant)
            SEXT_1: begin
                tx = a_q30 - b_q30;  ty = 2 * b_q30;
                da = one_q30 - tx - ty; db = da + 2 * tx; dc = db + 2 * ty;
            end
            SEXT_2: begin
                tx = a_q30 + b_q30;  ty = b_q30 - a_q30;
                db = one_q30 - tx - ty; da = db + 2 * ty; dc = da + 2 * tx;
            end
            SEXT_3: begin
                tx = 2 * b_q30;      ty = -a_q30 - b_q30;
                db = one_q30 - tx - ty; dc = db + 2 * tx; da = dc + 2 * ty;
            end
            SEXT_4: begin
                tx = b_q30 - a_q30;  ty = -2 * b_q30;
                dc = one_q30 - tx - ty; db = dc + 2 * ty; da = db + 2 * tx;
            end
            SEXT_5: begin
                tx = -a_q30 - b_q30; ty = a_q30 - b_q30;
                dc = one_q30 - tx - ty; da = dc + 2 * tx; db = da + 2 * ty;
            end
            default: begin
                tx = -2 * b_q30;     ty = a_q30 + b_q30;
                da = one_q30 - tx - ty; dc = da + 2 * ty; db = dc + 2 * tx;
            end
        endcase

        r.duty_a   = sat_q15(da, ok);
        r.duty_b   = sat_q15(db, ok);
        r.duty_c   = sat_q15(dc, ok);
        r.in_range = ok;
        return r;
    endfunction

    task automatic add_row(int alpha, int beta, bit known,
                           int da, int db, int dc, logic [SEXT_W-1:0] sx, bit ok);
        t_vec_row row;
        row.alpha       = IN_W'(alpha);
        row.beta        = IN_W'(beta);
        row.known       = known;
        row.res.duty_a  = DUTY_W'(da);
        row.res.duty_b  = DUTY_W'(db);
        row.res.duty_c  = DUTY_W'(dc);
        row.res.sextant = sx;
        row.res.in_range = ok;
        vec_rows.push_back(row);
    endtask

    // Present one vector, after an optional random gap, and hold it until taken; entered and left at a rising edge
    task automatic drive_vec(logic signed [IN_W-1:0] alpha, logic signed [IN_W-1:0] beta,
                             bit known, t_svpwm_res known_res);
        int gap;
        bit took;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            start        <= 1'b0;
            i_alpha_norm <= $urandom;
            i_beta_norm  <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_alpha_norm  <= alpha;
        i_beta_norm   <= beta;
        vec_known     <= known;
        vec_known_res <= known_res;
        do begin
            @(negedge i_clk);
            took = !busy;
            @(posedge i_clk);
        end while (!took);
    endtask

    // Hold off the sender until every result is back
    task automatic drain();
        start <= 1'b0;
        while (duty_q.size() != 0) @(posedge i_clk);
    endtask

    // Checker and stall watchdog; sampled mid-cycle, away from the driving edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (duty_q.size() == 0) begin
                $error("result beat with no vector outstanding");
                n_errors++;
            end else begin
                t_svpwm_res want;
                want = duty_q.pop_front();
                if (o_duty_a !== want.duty_a) begin
                    $error("duty_a: expected %0d, got %0d", want.duty_a, o_duty_a);
                    n_errors++;
                end
                if (o_duty_b !== want.duty_b) begin
                    $error("duty_b: expected %0d, got %0d", want.duty_b, o_duty_b);
                    n_errors++;
                end
                if (o_duty_c !== want.duty_c) begin
                    $error("duty_c: expected %0d, got %0d", want.duty_c, o_duty_c);
                    n_errors++;
                end
                if (o_sextant !== want.sextant) begin
                    $error("sextant: expected %0d, got %0d", want.sextant, o_sextant);
                    n_errors++;
                end
                if (o_in_range !== want.in_range) begin
                    $error("in_range: expected %0d, got %0d", want.in_range, o_in_range);
                    n_errors++;
                end
            end
        end
        // Beat taken at the coming edge
        if (i_rst_n && start && busy === 1'b0) begin
            duty_q.push_back(vec_known ? vec_known_res
                                       : svm_duties(i_alpha_norm, i_beta_norm));
        end
        if (i_rst_n && ((start && busy === 1'b0) || o_valid === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int         a_i;
        int         b_i;
        t_svpwm_res none;
        start         = 1'b0;
        i_rst_n       = 1'b0;
        i_alpha_norm  = '0;
        i_beta_norm   = '0;
        vec_known     = 1'b0;
        vec_known_res = '0;
        n_errors      = 0;
        idle_cycles   = 0;
        gaps_on       = 1'b1;
        none          = '0;

        // Extremes with results read straight off the equations
        add_row(0, 0, 1, 16384, 16384, 16384, SEXT_1, 1);
        add_row(32767, 0, 1, 0, 32768, 32768, SEXT_1, 0);
        add_row(-32768, 0, 1, 32768, 0, 0, SEXT_3, 0);
        add_row(0, 32767, 1, 16384, 0, 32768, SEXT_2, 0);
        add_row(0, -32768, 1, 16384, 32768, 0, SEXT_5, 0);
        // Duties landing exactly on 0 and full scale stay in range
        add_row(16384, 0, 1, 0, 32768, 32768, SEXT_1, 1);
        add_row(16385, 0, 0, 0, 0, 0, SEXT_1, 0);
        // Corners
        add_row(32767, 32767, 0, 0, 0, 0, SEXT_1, 0);
        add_row(-32768, -32768, 0, 0, 0, 0, SEXT_1, 0);
        add_row(32767, -32768, 0, 0, 0, 0, SEXT_1, 0);
        add_row(-32768, 32767, 0, 0, 0, 0, SEXT_1, 0);
        // Sign borders around zero
        add_row(-1, 0, 0, 0, 0, 0, SEXT_1, 0);
        add_row(0, -1, 0, 0, 0, 0, SEXT_1, 0);
        add_row(-1, -1, 0, 0, 0, 0, SEXT_1, 0);
        // One vector inside each sextant
        add_row(8000, 2000, 0, 0, 0, 0, SEXT_1, 0);
        add_row(3000, 9000, 0, 0, 0, 0, SEXT_1, 0);
        add_row(-8000, 2000, 0, 0, 0, 0, SEXT_1, 0);
        add_row(-8000, -2000, 0, 0, 0, 0, SEXT_1, 0);
        add_row(1000, -9000, 0, 0, 0, 0, SEXT_1, 0);
        add_row(8000, -2000, 0, 0, 0, 0, SEXT_1, 0);
        // Both sides of the first-quadrant beta = sqrt3 * alpha border, then points next to its mirrored borders
        add_row(4000, 6928, 0, 0, 0, 0, SEXT_1, 0);
        add_row(4000, 6929, 0, 0, 0, 0, SEXT_1, 0);
        add_row(-4000, 6928, 0, 0, 0, 0, SEXT_1, 0);
        add_row(-4000, -6928, 0, 0, 0, 0, SEXT_1, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (vec_rows[i]) begin
            drive_vec(vec_rows[i].alpha, vec_rows[i].beta, vec_rows[i].known,
                      vec_rows[i].res);
        end
        drain();

        // Random vectors: half near the modulation range, the rest full scale, sextant borders and axes
        for (int n = 0; n < RANDOM_VECS; n++) begin
            if (n % 50 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            if (n == RANDOM_VECS / 2) drain();
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    a_i = $urandom_range(0, 65535) - 32768;
                    b_i = $urandom_range(0, 65535) - 32768;
                end
                3: begin
                    a_i = $urandom_range(0, 18000) - 9000;
                    b_i = (a_i * 56756) / 32768 + int'($urandom_range(0, 4)) - 2;
                    if ($urandom_range(0, 1)) b_i = -b_i;
                end
                4: begin
                    a_i = $urandom_range(0, 65535) - 32768;
                    b_i = $urandom_range(0, 1) ? 0 : $urandom_range(0, 2) - 1;
                    if ($urandom_range(0, 1)) begin
                        b_i = a_i;
                        a_i = $urandom_range(0, 2) - 1;
                    end
                end
                default: begin
                    a_i = $urandom_range(0, 40000) - 20000;
                    b_i = $urandom_range(0, 40000) - 20000;
                end
            endcase
            drive_vec(IN_W'(a_i), IN_W'(b_i), 1'b0, none);
        end

        // Let the pipe empty, then keep watching for stray beats before the verdict
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
